// File: design/date_string_validator_defines.svh
// Assertion helpers used by date_string_validator.sv.
`ifndef DATE_STRING_VALIDATOR_DEFINES_SVH
`define DATE_STRING_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DSV_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dsv: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DSV_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dsv: next-cycle check failed");

`endif

// File: design/dsv_pkg.sv
package dsv_pkg;

    localparam int SYMBOL_W = 8;

    localparam logic [SYMBOL_W-1:0] SEPARATOR  = 8'h2F;
    localparam logic [SYMBOL_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [SYMBOL_W-1:0] DIGIT_NINE = 8'h39;

    localparam int SHORT_FIELD_DIGITS = 3;
    localparam int DAY_W              = 10;
    localparam int YMOD_W             = 9;
    localparam int YACC_W             = 12;

    localparam int DAY_MAX      = 31;
    localparam int DAY_MAX_30   = 30;
    localparam int MONTH_MAX    = 12;
    localparam int FEB_LEAP     = 29;
    localparam int FEB_COMMON   = 28;
    localparam int CENTURY      = 100;
    localparam int LEAP_PERIOD  = 400;
    localparam int LEAP_STEPS   = 9;

    localparam int MONTH_FEB = 2;
    localparam int MONTH_APR = 4;
    localparam int MONTH_JUN = 6;
    localparam int MONTH_SEP = 9;
    localparam int MONTH_NOV = 11;

    typedef enum logic [2:0] {
        F_DAY   = 3'b001,
        F_MONTH = 3'b010,
        F_YEAR  = 3'b100
    } t_field;

endpackage

// File: design/dsv_in_if.sv
interface dsv_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsv_pkg::SYMBOL_W-1:0]  symbol;
    logic                          end_of_string;

    modport source (output valid, output symbol, output end_of_string, input ready);
    modport sink   (input valid, input symbol, input end_of_string, output ready);
endinterface

// File: design/dsv_out_if.sv
interface dsv_out_if;
    logic valid;
    logic ready;
    logic date_valid;

    modport source (output valid, output date_valid, input ready);
    modport sink   (input valid, input date_valid, output ready);
endinterface

// File: design/date_string_validator.sv
// Date string checker, day/month/year.
// i_in carries one ASCII character per transfer in symbol; end_of_string
// marks the last character. o_out carries one date_valid bit per string,
// sent once the last character has been processed.
// Each character is registered on input, then folded into the field,
// digit count, day, month and year-residue registers. A last
// character's result goes via the input and output registers to o_out.
// Throughput: one character per cycle unless a last character waits on
// a stalled o_out, set by the single per-character field register update.
// Reset (synchronous, active low) clears the input and output stages and
// returns the parse state to the start of the day field.
// If the receiver stalls o_out, the result is held; characters that are
// not last keep flowing, and a second last character waits in the input
// register, which then stops further transfers on i_in.
// Up to YEAR_DIGITS digits are taken in the year field.
`include "date_string_validator_defines.svh"

module date_string_validator #(
    parameter int YEAR_DIGITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dsv_in_if.sink            i_in,
    dsv_out_if.source         o_out
);

    localparam int MAX_DIGITS = (YEAR_DIGITS > dsv_pkg::SHORT_FIELD_DIGITS) ?
                                YEAR_DIGITS : dsv_pkg::SHORT_FIELD_DIGITS;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam int DW = dsv_pkg::DAY_W;
    localparam int MW = dsv_pkg::YMOD_W;
    localparam int AW = dsv_pkg::YACC_W;

    function automatic logic [MW-1:0] f_mod400(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = a;
        for (int k = 1; k <= dsv_pkg::LEAP_STEPS; k++) begin
            if (a >= AW'(k * dsv_pkg::LEAP_PERIOD)) begin
                r = a - AW'(k * dsv_pkg::LEAP_PERIOD);
            end
        end
        return r[MW-1:0];
    endfunction

    logic                          r_in_valid;
    logic [dsv_pkg::SYMBOL_W-1:0]  r_in_symbol;
    logic                          r_in_eos;
    logic                          r_out_valid;
    logic                          r_date_valid;

    dsv_pkg::t_field               r_field,  n_field;
    logic [CNT_W-1:0]              r_count,  n_count;
    logic [DW-1:0]                 r_day,    n_day;
    logic [DW-1:0]                 r_month,  n_month;
    logic [MW-1:0]                 r_ymod,   n_ymod;
    logic                          r_ynz,    n_ynz;
    logic                          r_failed, n_failed;

    logic                          out_free;
    logic                          proc_go;
    logic                          in_ready;
    logic                          is_digit;
    logic [3:0]                    digit;
    logic [CNT_W-1:0]              limit;
    logic [AW-1:0]                 yacc;
    logic                          century;
    logic                          leap;
    logic                          short_month;
    logic                          date_ok;

    assign out_free = !r_out_valid || o_out.ready;
    assign proc_go  = r_in_valid && (!r_in_eos || out_free);
    assign in_ready = !r_in_valid || proc_go;

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.date_valid = r_date_valid;

    assign is_digit = (r_in_symbol >= dsv_pkg::DIGIT_ZERO) &&
                      (r_in_symbol <= dsv_pkg::DIGIT_NINE);
    assign digit    = r_in_symbol[3:0];
    assign limit    = (r_field == dsv_pkg::F_YEAR) ? CNT_W'(YEAR_DIGITS) :
                      CNT_W'(dsv_pkg::SHORT_FIELD_DIGITS);
    assign yacc     = ({{(AW-MW){1'b0}}, r_ymod} << 3) +
                      ({{(AW-MW){1'b0}}, r_ymod} << 1) + AW'(digit);

    always_comb begin
        n_field  = r_field;
        n_count  = r_count;
        n_day    = r_day;
        n_month  = r_month;
        n_ymod   = r_ymod;
        n_ynz    = r_ynz;
        n_failed = r_failed;
        priority if (r_in_symbol == dsv_pkg::SEPARATOR) begin
            if (r_field == dsv_pkg::F_YEAR || r_count == '0) begin
                n_failed = 1'b1;
            end else begin
                n_count = '0;
                n_field = (r_field == dsv_pkg::F_DAY) ? dsv_pkg::F_MONTH : dsv_pkg::F_YEAR;
            end
        end else if (is_digit) begin
            if (r_count >= limit) begin
                n_failed = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
                unique case (r_field)
                    dsv_pkg::F_DAY: begin
                        n_day = (r_day << 3) + (r_day << 1) + DW'(digit);
                    end
                    dsv_pkg::F_MONTH: begin
                        n_month = (r_month << 3) + (r_month << 1) + DW'(digit);
                    end
                    dsv_pkg::F_YEAR: begin
                        n_ymod = f_mod400(yacc);
                        n_ynz  = r_ynz || (digit != 4'd0);
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end
        end else begin
            n_failed = 1'b1;
        end
    end

    always_comb begin
        century = (n_ymod == MW'(dsv_pkg::CENTURY)) ||
                  (n_ymod == MW'(2 * dsv_pkg::CENTURY)) ||
                  (n_ymod == MW'(3 * dsv_pkg::CENTURY));
        leap    = (n_ymod[1:0] == 2'd0) && (!century || n_ymod == '0);
        short_month = (n_month == DW'(dsv_pkg::MONTH_APR)) ||
                      (n_month == DW'(dsv_pkg::MONTH_JUN)) ||
                      (n_month == DW'(dsv_pkg::MONTH_SEP)) ||
                      (n_month == DW'(dsv_pkg::MONTH_NOV));
        date_ok = !n_failed && (n_field == dsv_pkg::F_YEAR) && (n_count != '0) &&
                  (n_day != '0) && (n_day <= DW'(dsv_pkg::DAY_MAX)) &&
                  (n_month != '0) && (n_month <= DW'(dsv_pkg::MONTH_MAX)) &&
                  !(short_month && n_day > DW'(dsv_pkg::DAY_MAX_30)) &&
                  !(n_month == DW'(dsv_pkg::MONTH_FEB) &&
                    n_day > (leap ? DW'(dsv_pkg::FEB_LEAP) : DW'(dsv_pkg::FEB_COMMON))) &&
                  n_ynz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_field     <= dsv_pkg::F_DAY;
            r_count     <= '0;
            r_day       <= '0;
            r_month     <= '0;
            r_ymod      <= '0;
            r_ynz       <= 1'b0;
            r_failed    <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc_go && r_in_eos) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (proc_go) begin
                if (r_in_eos) begin
                    r_field  <= dsv_pkg::F_DAY;
                    r_count  <= '0;
                    r_day    <= '0;
                    r_month  <= '0;
                    r_ymod   <= '0;
                    r_ynz    <= 1'b0;
                    r_failed <= 1'b0;
                end else begin
                    r_field  <= n_field;
                    r_count  <= n_count;
                    r_day    <= n_day;
                    r_month  <= n_month;
                    r_ymod   <= n_ymod;
                    r_ynz    <= n_ynz;
                    r_failed <= n_failed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_symbol <= i_in.symbol;
            r_in_eos    <= i_in.end_of_string;
        end
        if (proc_go && r_in_eos) begin
            r_date_valid <= date_ok;
        end
    end

    `DSV_ASSERT_NEXT(a_result_after_last, i_clk, i_rst_n,
        proc_go && r_in_eos, r_out_valid)
    `DSV_ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n,
        proc_go && r_in_eos,
        r_field == dsv_pkg::F_DAY && r_count == '0 && !r_failed && !r_ynz)
    `DSV_ASSERT_NOW(a_stall_only_on_last, i_clk, i_rst_n,
        r_in_valid && !proc_go, r_in_eos && r_out_valid && !o_out.ready)

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_DIGITS   = 4;
    localparam int RANDOM_CHARS  = 600;
    localparam int HOLD_OFF      = 250;
    localparam int DRAIN_CYCLES  = 10;

    typedef logic [dsv_pkg::SYMBOL_W-1:0] t_char_q[$];

    logic i_clk;
    logic i_rst_n;

    dsv_in_if  in_ch ();
    dsv_out_if out_ch ();

    date_string_validator #(
        .YEAR_DIGITS (YEAR_DIGITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // parser state mirror
    dsv_pkg::t_field cur_field;
    logic [2:0]  field_digits;
    logic [9:0]  day_acc;
    logic [9:0]  month_acc;
    logic [13:0] year_acc;
    bit          parse_failed;

    logic expected_verdicts[$];
    logic want_verdict;

    int fail_count;
    int chars_sent;
    int strings_sent;
    int verdicts_checked;
    int valid_dates;
    int burst_left;
    int hold_request;
    int hold_left;
    int seg_left;
    int stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("date_string_validator regression: fail");
        $finish;
    end

    function automatic void clear_parser();
        cur_field    = dsv_pkg::F_DAY;
        field_digits = '0;
        day_acc      = '0;
        month_acc    = '0;
        year_acc     = '0;
        parse_failed = 1'b0;
    endfunction

    function automatic bit calendar_ok(logic [9:0] d, logic [9:0] m, logic [13:0] y);
        bit leap;
        int feb_max;
        leap    = (y % 4 == 0) &&
                  ((y % dsv_pkg::CENTURY != 0) || (y % dsv_pkg::LEAP_PERIOD == 0));
        feb_max = leap ? dsv_pkg::FEB_LEAP : dsv_pkg::FEB_COMMON;
        if (d < 1 || d > dsv_pkg::DAY_MAX)
            return 1'b0;
        if (m < 1 || m > dsv_pkg::MONTH_MAX)
            return 1'b0;
        if (d > dsv_pkg::DAY_MAX_30 && (m == dsv_pkg::MONTH_APR || m == dsv_pkg::MONTH_JUN ||
                                        m == dsv_pkg::MONTH_SEP || m == dsv_pkg::MONTH_NOV))
            return 1'b0;
        if (m == dsv_pkg::MONTH_FEB && d > feb_max)
            return 1'b0;
        if (y == 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void parse_symbol(input logic [dsv_pkg::SYMBOL_W-1:0] ch,
                                         input logic last,
                                         output bit has_verdict, output logic verdict);
        int limit;
        logic [3:0] v;
        limit       = (cur_field == dsv_pkg::F_YEAR) ? YEAR_DIGITS :
                      dsv_pkg::SHORT_FIELD_DIGITS;
        v           = 4'(ch - dsv_pkg::DIGIT_ZERO);
        has_verdict = 1'b0;
        verdict     = 1'b0;
        if (ch == dsv_pkg::SEPARATOR) begin
            if (cur_field == dsv_pkg::F_YEAR || field_digits == 0) begin
                parse_failed = 1'b1;
            end else begin
                cur_field    = (cur_field == dsv_pkg::F_DAY) ? dsv_pkg::F_MONTH :
                               dsv_pkg::F_YEAR;
                field_digits = '0;
            end
        end else if (ch >= dsv_pkg::DIGIT_ZERO && ch <= dsv_pkg::DIGIT_NINE) begin
            if (field_digits >= limit) begin
                parse_failed = 1'b1;
            end else begin
                case (cur_field)
                    dsv_pkg::F_DAY:   day_acc   = 10'(day_acc * 10 + v);
                    dsv_pkg::F_MONTH: month_acc = 10'(month_acc * 10 + v);
                    default:          year_acc  = 14'(year_acc * 10 + v);
                endcase
                field_digits = field_digits + 3'd1;
            end
        end else begin
            parse_failed = 1'b1;
        end
        if (last) begin
            has_verdict = 1'b1;
            verdict = !parse_failed && cur_field == dsv_pkg::F_YEAR && field_digits != 0 &&
                      calendar_ok(day_acc, month_acc, year_acc);
            clear_parser();
        end
    endfunction

    // sender: bursts of random length, random gaps; called and returns at a falling edge
    task automatic send_char(input logic [dsv_pkg::SYMBOL_W-1:0] ch, input logic last);
        int gap;
        bit has_verdict;
        logic verdict;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid         <= 1'b1;
        in_ch.symbol        <= ch;
        in_ch.end_of_string <= last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        parse_symbol(ch, last, has_verdict, verdict);
        if (has_verdict) begin
            expected_verdicts.push_back(verdict);
            strings_sent++;
        end
        chars_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_string(input t_char_q chars);
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
    endtask

    function automatic t_char_q chars_of(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic int decimal_width(input int value);
        int w;
        w = 1;
        while (value >= 10) begin
            value /= 10;
            w++;
        end
        return w;
    endfunction

    function automatic t_char_q decimal_chars(input int value, input int width);
        t_char_q q;
        for (int i = 0; i < width; i++) begin
            q.push_front(dsv_pkg::DIGIT_ZERO + dsv_pkg::SYMBOL_W'(value % 10));
            value /= 10;
        end
        return q;
    endfunction

    function automatic t_char_q build_date();
        int years[] = '{0, 4, 100, 400, 1600, 1900, 2000, 2023, 2024, 2100, 9996, 9999};
        int d, m, y, pos, kind;
        t_char_q q;
        case ($urandom_range(0, 9))
            0:       d = $urandom_range(0, 999);
            1:       d = $urandom_range(28, 32);
            2:       d = 0;
            default: d = $urandom_range(1, 31);
        endcase
        case ($urandom_range(0, 9))
            0:       m = $urandom_range(0, 999);
            1:       m = $urandom_range(0, 13);
            default: m = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 5))
            0, 1:    y = years[$urandom_range(0, years.size() - 1)];
            2:       y = $urandom_range(0, 99);
            default: y = $urandom_range(1, 9999);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            m = dsv_pkg::MONTH_FEB;
            d = $urandom_range(27, 30);
        end
        q = decimal_chars(d, $urandom_range(decimal_width(d), dsv_pkg::SHORT_FIELD_DIGITS));
        q.push_back(dsv_pkg::SEPARATOR);
        q = {q, decimal_chars(m, $urandom_range(decimal_width(m),
                                                dsv_pkg::SHORT_FIELD_DIGITS))};
        q.push_back(dsv_pkg::SEPARATOR);
        q = {q, decimal_chars(y, $urandom_range(decimal_width(y), YEAR_DIGITS))};

        kind = $urandom_range(0, 99);
        pos  = $urandom_range(0, q.size() - 1);
        if (kind < 75) begin
        end else if (kind < 80) begin
            q[pos] = dsv_pkg::SYMBOL_W'($urandom_range(0, 255));
        end else if (kind < 84) begin
            q.delete(pos);
        end else if (kind < 88) begin
            q.insert(pos, dsv_pkg::SEPARATOR);
        end else if (kind < 93) begin
            q.insert(pos, dsv_pkg::DIGIT_ZERO + dsv_pkg::SYMBOL_W'($urandom_range(0, 9)));
        end else begin
            q.delete();
            repeat ($urandom_range(1, 12))
                q.push_back(dsv_pkg::SYMBOL_W'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    // receiver: random segments of steady or stalled ready, plus the long hold-off
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 60);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 70;
                    default: stall_pct = 30;
                endcase
            end
            seg_left--;
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("date_valid: unexpected transfer, actual %0b", out_ch.date_valid);
                fail_count++;
            end else begin
                want_verdict = expected_verdicts.pop_front();
                verdicts_checked++;
                if (want_verdict)
                    valid_dates++;
                if (out_ch.date_valid !== want_verdict) begin
                    $error("date_valid: expected %0b, actual %0b",
                           want_verdict, out_ch.date_valid);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_string(chars_of("1/1/1"));
        send_string(chars_of("/"));
        send_string(chars_of("7"));
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_string(chars_of("1/1//"));
        send_string(chars_of("1111"));
        send_string(chars_of("1/1/"));
    endtask

    task automatic test_random_dates();
        int start;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
            send_string(build_date());
    endtask

    // output held off long enough that the block backs up and stalls its input
    task automatic test_output_backpressure();
        hold_request = HOLD_OFF;
        repeat (40)
            send_string(build_date());
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.symbol        = '0;
        in_ch.end_of_string = 1'b0;
        out_ch.ready        = 1'b0;
        fail_count          = 0;
        chars_sent          = 0;
        strings_sent        = 0;
        verdicts_checked    = 0;
        valid_dates         = 0;
        burst_left          = 0;
        hold_request        = 0;
        hold_left           = 0;
        seg_left            = 0;
        stall_pct           = 0;
        clear_parser();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_dates();
        test_output_backpressure();
        test_random_dates();

        in_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_verdicts.size() != 0) begin
            $error("date_valid: %0d expected transfers never arrived",
                   expected_verdicts.size());
            fail_count++;
        end
        $display("covered %0d characters in %0d strings, %0d verdicts checked, %0d valid dates",
                 chars_sent, strings_sent, verdicts_checked, valid_dates);
        $display("edge cases, leap-year and corrupted dates, %0d-cycle output hold-off",
                 HOLD_OFF);
        if (fail_count == 0)
            $display("date_string_validator regression: pass");
        else
            $display("date_string_validator regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/dsv_pkg.sv
design/dsv_in_if.sv
design/dsv_out_if.sv
design/date_string_validator.sv
tb/tb_top.sv
